>>> rtl/scp_pkg.sv
`default_nettype none

package scp_pkg;

  // field widths
  localparam int unsigned START_W  = 48;
  localparam int unsigned END_W    = 56;
  localparam int unsigned LOW_W    = 16;
  localparam int unsigned PREFIX_W = END_W - LOW_W;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned IN_W     = 64;

  localparam int unsigned MAX_RESULTS = 3;

  localparam logic [CNT_W-1:0] CPF_RESET = 32'd1048576;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_ROW    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_UNSORTED   = 3'd1,
    ERR_START_WIDE = 3'd2,
    ERR_END_WIDE   = 3'd3,
    ERR_FATAL      = 3'd4
  } err_e;

  typedef struct packed {
    kind_e                kind;
    logic [START_W-1:0]   record_start;
    logic [LOW_W-1:0]     record_end_low;
    logic [PREFIX_W-1:0]  row_prefix;
    logic [CNT_W-1:0]     row_first;
    logic [LOW_W-1:0]     row_count;
    logic [CNT_W-1:0]     file_number;
    logic                 closes_file;
    err_e                 error_code;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [END_W-1:0]    previous_end;
    logic [PREFIX_W-1:0] current_prefix;
    logic [CNT_W-1:0]    prefix_first;
    logic [CNT_W-1:0]    chains_in_file;
    logic [CNT_W-1:0]    file_count;
    logic                file_open;
    logic                fatal_stop;
  } state_t;

  // empty result tagged with the current file
  function automatic result_t blank_result(input logic [CNT_W-1:0] file_number);
    result_t r;
    r             = '0;
    r.kind        = KIND_RECORD;
    r.error_code  = ERR_NONE;
    r.file_number = file_number;
    return r;
  endfunction

  function automatic result_t error_result(input logic [CNT_W-1:0] file_number,
                                           input err_e code);
    result_t r;
    r            = blank_result(file_number);
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic result_t row_result(input logic [CNT_W-1:0]    file_number,
                                         input logic [PREFIX_W-1:0] prefix,
                                         input logic [CNT_W-1:0]    first,
                                         input logic [CNT_W-1:0]    chains,
                                         input logic                closes);
    result_t          r;
    logic [CNT_W-1:0] span;
    span          = chains - first;
    r             = blank_result(file_number);
    r.kind        = KIND_ROW;
    r.row_prefix  = prefix;
    r.row_first   = first;
    r.row_count   = span[LOW_W-1:0];
    r.closes_file = closes;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/scp_step.sv
`default_nettype none

// one item against the current state: results and next state
module scp_step (
  input  var scp_pkg::state_t                                 state_i,
  input  wire                                                 mode_i,
  input  wire  [scp_pkg::IN_W-1:0]                            start_i,
  input  wire  [scp_pkg::IN_W-1:0]                            end_i,
  input  wire  [scp_pkg::CNT_W-1:0]                           cpf_i,
  output scp_pkg::state_t                                     state_o,
  output scp_pkg::result_t [scp_pkg::MAX_RESULTS-1:0]         res_o,
  output logic [1:0]                                          count_o
);

  logic [scp_pkg::PREFIX_W-1:0] prefix;
  logic [scp_pkg::CNT_W-1:0]    chains_inc;
  logic [1:0]                   k;

  assign prefix     = end_i[scp_pkg::END_W-1:scp_pkg::LOW_W];
  assign chains_inc = state_i.chains_in_file + 1'b1;

  always_comb begin
    state_o = state_i;
    k       = 2'd0;
    for (int i = 0; i < scp_pkg::MAX_RESULTS; i++) begin
      res_o[i] = scp_pkg::blank_result(state_i.file_count);
    end

    if (state_i.fatal_stop) begin
      res_o[0] = scp_pkg::error_result(state_i.file_count, scp_pkg::ERR_FATAL);
      k        = 2'd1;
    end else if (mode_i) begin
      // flush: closing row of an open file
      if (state_i.file_open) begin
        res_o[0] = scp_pkg::row_result(state_i.file_count, state_i.current_prefix,
                                       state_i.prefix_first, state_i.chains_in_file, 1'b1);
        state_o.file_count     = state_i.file_count + 1'b1;
        state_o.chains_in_file = '0;
        state_o.prefix_first   = '0;
        state_o.file_open      = 1'b0;
        k                      = 2'd1;
      end
    end else begin
      state_o.file_open = 1'b1;
      if (start_i == '0) begin
        k = 2'd0;
      end else if (end_i != '0 &&
                   {{(scp_pkg::IN_W-scp_pkg::END_W){1'b0}}, state_i.previous_end} >= end_i)
      begin
        res_o[0] = scp_pkg::error_result(state_i.file_count, scp_pkg::ERR_UNSORTED);
        k        = 2'd1;
      end else if (start_i[scp_pkg::IN_W-1:scp_pkg::START_W] != '0) begin
        res_o[0] = scp_pkg::error_result(state_i.file_count, scp_pkg::ERR_START_WIDE);
        k        = 2'd1;
      end else if (end_i[scp_pkg::IN_W-1:scp_pkg::END_W] != '0) begin
        res_o[0] = scp_pkg::error_result(state_i.file_count, scp_pkg::ERR_END_WIDE);
        k        = 2'd1;
      end else begin
        res_o[0].record_start   = start_i[scp_pkg::START_W-1:0];
        res_o[0].record_end_low = end_i[scp_pkg::LOW_W-1:0];
        state_o.previous_end    = end_i[scp_pkg::END_W-1:0];
        k                       = 2'd1;
        if (prefix != state_i.current_prefix && prefix < state_i.current_prefix) begin
          // prefix went backwards: record stands, block stops for good
          res_o[1]           = scp_pkg::error_result(state_i.file_count, scp_pkg::ERR_FATAL);
          state_o.fatal_stop = 1'b1;
          k                  = 2'd2;
        end else begin
          if (prefix != state_i.current_prefix) begin
            res_o[1] = scp_pkg::row_result(state_i.file_count, state_i.current_prefix,
                                           state_i.prefix_first, state_i.chains_in_file,
                                           1'b0);
            state_o.prefix_first   = state_i.chains_in_file;
            state_o.current_prefix = prefix;
            k                      = 2'd2;
          end
          state_o.chains_in_file = chains_inc;
          if (chains_inc >= cpf_i) begin
            res_o[k] = scp_pkg::row_result(state_i.file_count, state_o.current_prefix,
                                           state_o.prefix_first, chains_inc, 1'b1);
            state_o.file_count     = state_i.file_count + 1'b1;
            state_o.chains_in_file = '0;
            state_o.prefix_first   = '0;
            state_o.file_open      = 1'b0;
            k                      = k + 2'd1;
          end
        end
      end
    end

    for (int i = 0; i < scp_pkg::MAX_RESULTS; i++) begin
      res_o[i].last = (k != 2'd0) && (2'(i) == k - 2'd1);
    end
  end

  assign count_o = k;

endmodule

`default_nettype wire

>>> rtl/sorted_chain_packer_with_prefix_index_core.sv
`default_nettype none

// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: start_point, end_point; tuser: mode
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: record/row/error fields; tuser: kind;
//                                             tlast: last result of a request
// cfg       in   cfg_we_i                     cfg_wdata_i: chains_per_file
//
// a request is registered at the input, then evaluated against the chain
// state; its zero to three results land in a three-entry result buffer
// that drains one result per cycle while m_axis_tready is high, so
// single-result requests flow at one per cycle when the output does not stall
// reset clears all chain state and loads chains_per_file with 1048576
// the input register keeps accepting while the buffer holds its final result,
// so output stalls only block the input once both stages are full
module sorted_chain_packer_with_prefix_index_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  // slave side
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [127:0] s_axis_tdata,   // [63:0] start_point, [127:64] end_point
  input  wire          s_axis_tuser,   // [0] mode
  // master side
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [191:0] m_axis_tdata,   // [47:0] record_start, [63:48] record_end_low,
                                       // [103:64] row_prefix, [135:104] row_first,
                                       // [151:136] row_count, [183:152] file_number,
                                       // [184] closes_file, [187:185] error_code,
                                       // [191:188] zero
  output logic [1:0]   m_axis_tuser,   // [1:0] kind
  output logic         m_axis_tlast,
  // configuration
  input  wire          cfg_we_i,
  input  wire  [31:0]  cfg_wdata_i
);

  // input register
  logic                     in_valid_q;
  logic                     in_mode_q;
  logic [scp_pkg::IN_W-1:0] in_start_q;
  logic [scp_pkg::IN_W-1:0] in_end_q;

  // chains_per_file register and chain state
  logic [scp_pkg::CNT_W-1:0] cpf_q;
  scp_pkg::state_t           state_q;
  scp_pkg::state_t           state_d;

  // result buffer, entry 0 is presented on the output
  scp_pkg::result_t [scp_pkg::MAX_RESULTS-1:0] buf_q;
  scp_pkg::result_t [scp_pkg::MAX_RESULTS-1:0] res_d;
  logic [1:0]                                  cnt_q;
  logic [1:0]                                  res_cnt;

  logic s_fire;
  logic m_fire;
  logic consume;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign m_fire  = m_axis_tvalid && m_axis_tready;
  // evaluate the held request once the buffer is empty or empties this cycle
  assign consume = in_valid_q && ((cnt_q == 2'd0) || (cnt_q == 2'd1 && m_fire));

  assign s_axis_tready = !in_valid_q || consume;

  scp_step u_step (
    .state_i (state_q),
    .mode_i  (in_mode_q),
    .start_i (in_start_q),
    .end_i   (in_end_q),
    .cpf_i   (cpf_q),
    .state_o (state_d),
    .res_o   (res_d),
    .count_o (res_cnt)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cnt_q      <= 2'd0;
      cpf_q      <= scp_pkg::CPF_RESET;
      state_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        cpf_q <= cfg_wdata_i;
      end
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (consume) begin
        state_q <= state_d;
        cnt_q   <= res_cnt;
      end else if (m_fire) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_mode_q  <= s_axis_tuser;
      in_start_q <= s_axis_tdata[63:0];
      in_end_q   <= s_axis_tdata[127:64];
    end
    if (consume) begin
      buf_q <= res_d;
    end else if (m_fire) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tuser  = buf_q[0].kind;
  assign m_axis_tlast  = buf_q[0].last;
  assign m_axis_tdata  = {4'd0,
                          buf_q[0].error_code,
                          buf_q[0].closes_file,
                          buf_q[0].file_number,
                          buf_q[0].row_count,
                          buf_q[0].row_first,
                          buf_q[0].row_prefix,
                          buf_q[0].record_end_low,
                          buf_q[0].record_start};

endmodule

`default_nettype wire
